// ===== design/dssc_pkg.sv =====
package dssc_pkg;

   // Lexer phase of the numeric grammar
   typedef enum logic [2:0] {
      PH_START    = 3'd0,
      PH_INT      = 3'd1,
      PH_FRAC     = 3'd2,
      PH_EXP_E    = 3'd3,
      PH_EXP_SIGN = 3'd4,
      PH_EXP_DIG  = 3'd5,
      PH_NONE     = 3'd6,
      PH_TRAIL    = 3'd7
   } phase_type;

   // Verdict codes on the result channel
   typedef enum logic [2:0] {
      V_OK       = 3'd0,
      V_EMPTY    = 3'd1,
      V_NAN      = 3'd2,
      V_TRAILING = 3'd3,
      V_INF      = 3'd4
   } verdict_type;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CNT_W      = 4;
   localparam int unsigned INF_LEN    = 8;
   localparam int unsigned INF_SHORT  = 3;

   localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2e;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [BYTE_W-1:0] CH_E_LO  = 8'h65;
   localparam logic [BYTE_W-1:0] CH_E_UP  = 8'h45;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_A_UP  = 8'h41;
   localparam logic [BYTE_W-1:0] CH_Z_UP  = 8'h5a;
   localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

   // Result of one lexer step toward the output register
   typedef struct packed {
      logic        valid;
      verdict_type verdict;
   } result_type;

   // Letters of the word "infinity", lower case
   function automatic logic [BYTE_W-1:0] inf_char(input logic [2:0] idx);
      logic [BYTE_W-1:0] ch;
      case (idx)
         3'd0: ch = 8'h69;
         3'd1: ch = 8'h6e;
         3'd2: ch = 8'h66;
         3'd3: ch = 8'h69;
         3'd4: ch = 8'h6e;
         3'd5: ch = 8'h69;
         3'd6: ch = 8'h74;
         3'd7: ch = 8'h79;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== design/dssc_lexer.sv =====
module dssc_lexer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [dssc_pkg::BYTE_W-1:0]   data_byte,
   input  logic                          last_byte,
   input  logic                          empty_string,
   output dssc_pkg::result_type          result
);

   dssc_pkg::phase_type             phase_ff, phase_in, phase_step;
   logic                            mant_seen_ff, mant_seen_in, mant_seen_step;
   logic                            exp_seen_ff, exp_seen_in, exp_seen_step;
   logic [dssc_pkg::CNT_W-1:0]      match_cnt_ff, match_cnt_in, match_cnt_step;
   logic                            mismatch_ff, mismatch_in, mismatch_step;
   logic                            first_ff, first_in;

   logic                            is_digit, is_sign, is_exp;
   logic [dssc_pkg::BYTE_W-1:0]     lower_byte;
   logic                            no_number;
   dssc_pkg::verdict_type           verdict;

   // Classify the byte
   always_comb begin
      is_digit = (data_byte >= dssc_pkg::CH_ZERO) && (data_byte <= dssc_pkg::CH_NINE);
      is_sign  = (data_byte == dssc_pkg::CH_PLUS) || (data_byte == dssc_pkg::CH_MINUS);
      is_exp   = (data_byte == dssc_pkg::CH_E_LO) || (data_byte == dssc_pkg::CH_E_UP);
      lower_byte = data_byte;
      if ((data_byte >= dssc_pkg::CH_A_UP) && (data_byte <= dssc_pkg::CH_Z_UP)) begin
         lower_byte = data_byte | dssc_pkg::CASE_BIT;
      end
   end

   // Advance the grammar scanner by one byte
   always_comb begin
      phase_step     = phase_ff;
      mant_seen_step = mant_seen_ff;
      exp_seen_step  = exp_seen_ff;
      case (phase_ff)
         dssc_pkg::PH_START, dssc_pkg::PH_INT: begin
            if (phase_ff == dssc_pkg::PH_START && is_sign) begin
               phase_step = dssc_pkg::PH_INT;
            end else if (is_digit) begin
               mant_seen_step = 1'b1;
               phase_step     = dssc_pkg::PH_INT;
            end else if (data_byte == dssc_pkg::CH_DOT) begin
               phase_step = dssc_pkg::PH_FRAC;
            end else if (is_exp && mant_seen_ff) begin
               phase_step = dssc_pkg::PH_EXP_E;
            end else begin
               phase_step = mant_seen_ff ? dssc_pkg::PH_TRAIL : dssc_pkg::PH_NONE;
            end
         end
         dssc_pkg::PH_FRAC: begin
            if (is_digit) begin
               mant_seen_step = 1'b1;
            end else if (is_exp && mant_seen_ff) begin
               phase_step = dssc_pkg::PH_EXP_E;
            end else begin
               phase_step = mant_seen_ff ? dssc_pkg::PH_TRAIL : dssc_pkg::PH_NONE;
            end
         end
         dssc_pkg::PH_EXP_E, dssc_pkg::PH_EXP_SIGN, dssc_pkg::PH_EXP_DIG: begin
            if (phase_ff == dssc_pkg::PH_EXP_E && is_sign) begin
               phase_step = dssc_pkg::PH_EXP_SIGN;
            end else if (is_digit) begin
               exp_seen_step = 1'b1;
               phase_step    = dssc_pkg::PH_EXP_DIG;
            end else begin
               phase_step = dssc_pkg::PH_TRAIL;
            end
         end
         default: begin
            phase_step = phase_ff;
         end
      endcase
   end

   // Advance the infinity matcher; skip a leading sign
   always_comb begin
      match_cnt_step = match_cnt_ff;
      mismatch_step  = mismatch_ff;
      if (!(first_ff && is_sign)) begin
         if (match_cnt_ff >= dssc_pkg::CNT_W'(dssc_pkg::INF_LEN)) begin
            mismatch_step = 1'b1;
         end else begin
            if (lower_byte != dssc_pkg::inf_char(match_cnt_ff[2:0])) begin
               mismatch_step = 1'b1;
            end
            match_cnt_step = match_cnt_ff + 1'b1;
         end
      end
   end

   // Judge the string as it stands after this byte
   always_comb begin
      no_number = 1'b0;
      verdict   = dssc_pkg::V_TRAILING;
      case (phase_step)
         dssc_pkg::PH_START, dssc_pkg::PH_INT, dssc_pkg::PH_FRAC: begin
            if (mant_seen_step) begin
               verdict = dssc_pkg::V_OK;
            end else begin
               no_number = 1'b1;
            end
         end
         dssc_pkg::PH_EXP_DIG: begin
            verdict = exp_seen_step ? dssc_pkg::V_OK : dssc_pkg::V_TRAILING;
         end
         dssc_pkg::PH_NONE: begin
            no_number = 1'b1;
         end
         default: begin
            verdict = dssc_pkg::V_TRAILING;
         end
      endcase
      if (no_number) begin
         if (!mismatch_step &&
             (match_cnt_step == dssc_pkg::CNT_W'(dssc_pkg::INF_SHORT) ||
              match_cnt_step == dssc_pkg::CNT_W'(dssc_pkg::INF_LEN))) begin
            verdict = dssc_pkg::V_INF;
         end else begin
            verdict = dssc_pkg::V_NAN;
         end
      end
      if (empty_string) begin
         verdict = dssc_pkg::V_EMPTY;
      end
   end

   assign result.valid   = advance && (last_byte || empty_string);
   assign result.verdict = verdict;

   // Select next string state: clear after a verdict
   always_comb begin
      phase_in     = phase_ff;
      mant_seen_in = mant_seen_ff;
      exp_seen_in  = exp_seen_ff;
      match_cnt_in = match_cnt_ff;
      mismatch_in  = mismatch_ff;
      first_in     = first_ff;
      if (advance) begin
         if (last_byte || empty_string) begin
            phase_in     = dssc_pkg::PH_START;
            mant_seen_in = 1'b0;
            exp_seen_in  = 1'b0;
            match_cnt_in = '0;
            mismatch_in  = 1'b0;
            first_in     = 1'b1;
         end else begin
            phase_in     = phase_step;
            mant_seen_in = mant_seen_step;
            exp_seen_in  = exp_seen_step;
            match_cnt_in = match_cnt_step;
            mismatch_in  = mismatch_step;
            first_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dssc_pkg::PH_START;
         mant_seen_ff <= 1'b0;
         exp_seen_ff  <= 1'b0;
         match_cnt_ff <= '0;
         mismatch_ff  <= 1'b0;
         first_ff     <= 1'b1;
      end else begin
         phase_ff     <= phase_in;
         mant_seen_ff <= mant_seen_in;
         exp_seen_ff  <= exp_seen_in;
         match_cnt_ff <= match_cnt_in;
         mismatch_ff  <= mismatch_in;
         first_ff     <= first_in;
      end
   end

endmodule

// ===== design/decimal_score_syntax_checker.sv =====
// Checks a number string, one byte per transfer, against a strict decimal
// grammar (optional sign, digits with optional fraction, optional complete
// exponent) and against the case-insensitive spellings inf and infinity.
// The transfer with tlast or the empty flag set yields one verdict transfer:
// ok, empty, not a number, trailing characters or infinite; other transfers
// yield nothing. A byte is taken every clock cycle unless a final byte
// is held back by a stalled result register. The final byte sits in the
// input register while the lexer judges it, and the result register then
// loads the verdict and presents it. A stalled result register holds the
// input side only when a verdict is waiting behind it.
module decimal_score_syntax_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   input  logic [0:0] req_tuser,   // [0] empty_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [2:0] verdict, [7:3] zero
);

   logic                          in_valid_ff, in_valid_in;
   logic [dssc_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                          in_last_ff, in_empty_ff;
   logic                          out_valid_ff, out_valid_in;
   dssc_pkg::verdict_type         out_verdict_ff;
   logic                          out_free, advance;
   dssc_pkg::result_type          result;

   // Move the held byte into the lexer; a final byte waits until its verdict has room
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (out_free || !(in_last_ff || in_empty_ff));
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = result.valid || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture input payload on a transfer
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_last_ff  <= req_tlast;
         in_empty_ff <= req_tuser[0];
      end
   end

   // Capture verdict
   always_ff @(posedge clock) begin
      if (result.valid) begin
         out_verdict_ff <= result.verdict;
      end
   end

   dssc_lexer u_lexer (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .data_byte    (in_byte_ff),
      .last_byte    (in_last_ff),
      .empty_string (in_empty_ff),
      .result       (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_verdict_ff};

endmodule
